>>> rtl/mfre_pkg.sv
package mfre_pkg;

  localparam int MAX_DIM_DEF      = 64;
  localparam int ELEMENT_BITS_DEF = 32;
  localparam int CMD_W            = 2;
  localparam int OP_W             = 3;
  localparam int CFG_DW           = 32;
  localparam int CFG_AW           = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_XFORM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [OP_W-1:0] OP_VFLIP = 3'd0;
  localparam logic [OP_W-1:0] OP_HFLIP = 3'd1;
  localparam logic [OP_W-1:0] OP_ROTR  = 3'd2;
  localparam logic [OP_W-1:0] OP_ROTL  = 3'd3;
  localparam logic [OP_W-1:0] OP_QCW   = 3'd4;
  localparam logic [OP_W-1:0] OP_QCCW  = 3'd5;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_XFORM,
    KIND_READ
  } kind_t;

  typedef struct packed {
    logic wr_rows;
    logic wr_cols;
  } cfg_wr_t;

endpackage

>>> rtl/mfre_front.sv
module mfre_front #(
  parameter int ELEMENT_BITS = 32,
  parameter int IDX_W        = 6,
  parameter int IN_TDW       = 56
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDW-1:0]         in_tdata,
  output logic                      q_valid,
  input  logic                      q_pop,
  output mfre_pkg::kind_t           q_kind,
  output logic [IDX_W-1:0]          q_row,
  output logic [IDX_W-1:0]          q_col,
  output logic [ELEMENT_BITS-1:0]   q_value,
  output logic [mfre_pkg::OP_W-1:0] q_op
);
  import mfre_pkg::*;

  localparam int ROW_LO = CMD_W;
  localparam int COL_LO = ROW_LO + IDX_W;
  localparam int VAL_LO = COL_LO + IDX_W;
  localparam int OP_LO  = VAL_LO + ELEMENT_BITS;

  logic [CMD_W-1:0]        cmd;
  logic [OP_W-1:0]         op;
  logic                    keep;
  logic                    push;
  kind_t                   kind;
  logic [1:0]              count_r;
  logic                    wp_r;
  logic                    rp_r;
  kind_t                   kind_q   [2];
  logic [IDX_W-1:0]        row_q    [2];
  logic [IDX_W-1:0]        col_q    [2];
  logic [ELEMENT_BITS-1:0] value_q  [2];
  logic [OP_W-1:0]         op_q     [2];

  assign cmd = in_tdata[CMD_W-1:0];
  assign op  = in_tdata[OP_LO +: OP_W];

  // Unknown commands and unknown transforms have no effect, so they never queue.
  always_comb begin
    keep = 1'b0;
    kind = KIND_LOAD;
    case (cmd)
      CMD_LOAD: begin
        keep = 1'b1;
        kind = KIND_LOAD;
      end
      CMD_XFORM: begin
        keep = (op <= OP_QCCW);
        kind = KIND_XFORM;
      end
      CMD_READ: begin
        keep = 1'b1;
        kind = KIND_READ;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (count_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wp_r]  <= kind;
      row_q[wp_r]   <= in_tdata[ROW_LO +: IDX_W];
      col_q[wp_r]   <= in_tdata[COL_LO +: IDX_W];
      value_q[wp_r] <= in_tdata[VAL_LO +: ELEMENT_BITS];
      op_q[wp_r]    <= op;
    end
  end

  assign q_kind  = kind_q[rp_r];
  assign q_row   = row_q[rp_r];
  assign q_col   = col_q[rp_r];
  assign q_value = value_q[rp_r];
  assign q_op    = op_q[rp_r];

endmodule

>>> rtl/mfre_back.sv
module mfre_back #(
  parameter int MAX_DIM      = 64,
  parameter int ELEMENT_BITS = 32,
  parameter int IDX_W        = 6,
  parameter int DIM_W        = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  mfre_pkg::kind_t           q_kind,
  input  logic [IDX_W-1:0]          q_row,
  input  logic [IDX_W-1:0]          q_col,
  input  logic [ELEMENT_BITS-1:0]   q_value,
  input  logic [mfre_pkg::OP_W-1:0] q_op,
  input  mfre_pkg::cfg_wr_t         cfg_wr,
  input  logic [DIM_W-1:0]          cfg_dim,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ELEMENT_BITS-1:0]   out_value,
  output logic [DIM_W-1:0]          out_rows,
  output logic [DIM_W-1:0]          out_cols
);
  import mfre_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_BACK,
    ST_DRAIN,
    ST_READ
  } state_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    logic [DIM_W-1:0] top;
    d   = v & ~DIM_W'(1);
    top = DIM_W'(MAX_DIM) & ~DIM_W'(1);
    if (d < DIM_W'(2)) d = DIM_W'(2);
    if (d > top) d = top;
    return d;
  endfunction

  state_t                  state_r;
  logic [DIM_W-1:0]        cur_rows_r;
  logic [DIM_W-1:0]        cur_cols_r;
  logic [DIM_W-1:0]        lim_rows_r;
  logic [DIM_W-1:0]        lim_cols_r;
  logic [OP_W-1:0]         op_r;
  logic [IDX_W-1:0]        i_r;
  logic [IDX_W-1:0]        j_r;
  logic                    wb_valid_r;
  logic                    wb_main_r;
  logic [AW-1:0]           wb_addr_r;
  logic                    rd_inside_r;
  logic                    out_valid_r;
  logic [ELEMENT_BITS-1:0] out_value_r;
  logic [DIM_W-1:0]        out_rows_r;
  logic [DIM_W-1:0]        out_cols_r;

  logic [ELEMENT_BITS-1:0] main_mem [DEPTH];
  logic [ELEMENT_BITS-1:0] scr_mem  [DEPTH];
  logic [ELEMENT_BITS-1:0] main_rd_r;
  logic [ELEMENT_BITS-1:0] scr_rd_r;

  logic                    main_we;
  logic [AW-1:0]           main_wa;
  logic [ELEMENT_BITS-1:0] main_wd;
  logic [AW-1:0]           main_ra;
  logic                    scr_we;

  logic [DIM_W-1:0]        si;
  logic [DIM_W-1:0]        sj;
  logic [AW-1:0]           src_addr;
  logic [AW-1:0]           dst_addr;
  logic [AW-1:0]           q_addr;
  logic                    q_inside;
  logic                    j_last;
  logic                    i_last;

  // Source position of destination (i, j) for the transform in flight.
  always_comb begin
    logic [DIM_W-1:0] ii;
    logic [DIM_W-1:0] jj;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] a;
    logic [DIM_W-1:0] b;
    logic             qi;
    logic             qj;
    logic             ti;
    logic             tj;
    ii = DIM_W'(i_r);
    jj = DIM_W'(j_r);
    h  = cur_rows_r >> 1;
    w  = cur_cols_r >> 1;
    qi = (ii >= h);
    qj = (jj >= w);
    a  = qi ? (ii - h) : ii;
    b  = qj ? (jj - w) : jj;
    ti = 1'b0;
    tj = 1'b0;
    si = ii;
    sj = jj;
    case (op_r)
      OP_VFLIP: si = cur_rows_r - DIM_W'(1) - ii;
      OP_HFLIP: sj = cur_cols_r - DIM_W'(1) - jj;
      OP_ROTR: begin
        si = cur_rows_r - DIM_W'(1) - jj;
        sj = ii;
      end
      OP_ROTL: begin
        si = jj;
        sj = cur_cols_r - DIM_W'(1) - ii;
      end
      OP_QCW: begin
        ti = !(qi ^ qj) ? !qi : 1'b0;
        tj = qi;
        if (!qi && !qj) begin
          ti = 1'b1;
          tj = 1'b0;
        end else if (!qi) begin
          ti = 1'b0;
          tj = 1'b0;
        end else if (qj) begin
          ti = 1'b0;
          tj = 1'b1;
        end else begin
          ti = 1'b1;
          tj = 1'b1;
        end
        si = ti ? (h + a) : a;
        sj = tj ? (w + b) : b;
      end
      OP_QCCW: begin
        if (!qi && !qj) begin
          ti = 1'b0;
          tj = 1'b1;
        end else if (!qi) begin
          ti = 1'b1;
          tj = 1'b1;
        end else if (qj) begin
          ti = 1'b1;
          tj = 1'b0;
        end else begin
          ti = 1'b0;
          tj = 1'b0;
        end
        si = ti ? (h + a) : a;
        sj = tj ? (w + b) : b;
      end
      default: begin
        si = ii;
        sj = jj;
      end
    endcase
  end

  assign src_addr = AW'(si) * AW'(MAX_DIM) + AW'(sj);
  assign dst_addr = AW'(i_r) * AW'(MAX_DIM) + AW'(j_r);
  assign q_addr   = AW'(q_row) * AW'(MAX_DIM) + AW'(q_col);
  assign q_inside = (DIM_W'(q_row) < cur_rows_r) && (DIM_W'(q_col) < cur_cols_r);
  assign j_last   = (DIM_W'(j_r) == lim_cols_r - DIM_W'(1));
  assign i_last   = (DIM_W'(i_r) == lim_rows_r - DIM_W'(1));

  assign q_pop = (state_r == ST_IDLE) && q_valid &&
                 ((q_kind != KIND_READ) || !out_valid_r);

  always_comb begin
    main_we = 1'b0;
    main_wa = q_addr;
    main_wd = q_value;
    if (wb_valid_r && wb_main_r) begin
      main_we = 1'b1;
      main_wa = wb_addr_r;
      main_wd = scr_rd_r;
    end else if (q_pop && (q_kind == KIND_LOAD) && q_inside) begin
      main_we = 1'b1;
    end
  end

  assign main_ra = (state_r == ST_COPY) ? src_addr : q_addr;
  assign scr_we  = wb_valid_r && !wb_main_r;

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_wa] <= main_wd;
    end
    main_rd_r <= main_mem[main_ra];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[wb_addr_r] <= main_rd_r;
    end
    scr_rd_r <= scr_mem[dst_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_rows_r  <= eff_dim(DIM_W'(MAX_DIM));
      cur_cols_r  <= eff_dim(DIM_W'(MAX_DIM));
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      wb_valid_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr.wr_rows) begin
        cur_rows_r <= eff_dim(cfg_dim);
      end
      if (cfg_wr.wr_cols) begin
        cur_cols_r <= eff_dim(cfg_dim);
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_kind)
              KIND_XFORM: begin
                op_r <= q_op;
                i_r  <= '0;
                j_r  <= '0;
                if (q_op == OP_ROTR || q_op == OP_ROTL) begin
                  lim_rows_r <= cur_cols_r;
                  lim_cols_r <= cur_rows_r;
                end else begin
                  lim_rows_r <= cur_rows_r;
                  lim_cols_r <= cur_cols_r;
                end
                state_r <= ST_COPY;
              end
              KIND_READ: begin
                rd_inside_r <= q_inside;
                out_rows_r  <= cur_rows_r;
                out_cols_r  <= cur_cols_r;
                state_r     <= ST_READ;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_COPY, ST_BACK: begin
          wb_valid_r <= 1'b1;
          wb_main_r  <= (state_r == ST_BACK);
          wb_addr_r  <= dst_addr;
          if (j_last) begin
            j_r <= '0;
            if (i_last) begin
              i_r     <= '0;
              state_r <= (state_r == ST_COPY) ? ST_BACK : ST_DRAIN;
            end else begin
              i_r <= i_r + IDX_W'(1);
            end
          end else begin
            j_r <= j_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          cur_rows_r <= lim_rows_r;
          cur_cols_r <= lim_cols_r;
          state_r    <= ST_IDLE;
        end
        ST_READ: begin
          out_valid_r <= 1'b1;
          out_value_r <= rd_inside_r ? main_rd_r : '0;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_rows  = out_rows_r;
  assign out_cols  = out_cols_r;

endmodule

>>> rtl/matrix_flip_rotate_engine_unit.sv
// Channel   Direction  Handshake                 Contents
// in_       slave      in_tvalid / in_tready     one command request
// out_      master     out_tvalid / out_tready   one read reply
// cfg_      APB slave  psel, penable, pready     row_count (0x0), col_count (0x4)
//
// A load is written to the matrix memory as it is popped; a read goes through ST_READ,
// with the reply held in an output register until it is taken. A transform on an R
// by C matrix runs two passes: one pass copies every element through the transform into a
// scratch memory, one pass copies it back, one element per cycle on each memory port.
// Reset is synchronous and active low; the matrix memories are not cleared and hold
// nothing meaningful until loaded. A two-entry request queue lets the input side
// keep accepting, until it is full, while a transform runs or a reply waits on out_tready.
module matrix_flip_rotate_engine_unit #(
  parameter int  MAX_DIM      = mfre_pkg::MAX_DIM_DEF,
  parameter int  ELEMENT_BITS = mfre_pkg::ELEMENT_BITS_DEF,
  localparam int IDX_W        = $clog2(MAX_DIM),
  localparam int DIM_W        = $clog2(MAX_DIM + 1),
  localparam int IN_W         = mfre_pkg::CMD_W + 2 * IDX_W + ELEMENT_BITS + mfre_pkg::OP_W,
  localparam int IN_TDW       = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W        = ELEMENT_BITS + 2 * DIM_W,
  localparam int OUT_TDW      = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // command, row_index, col_index, element_value, op_code (from bit 0), zero fill
  input  logic [IN_TDW-1:0]             in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // read_value, rows_now, cols_now (from bit 0), zero fill
  output logic [OUT_TDW-1:0]            out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mfre_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [mfre_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [mfre_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import mfre_pkg::*;

  logic                    q_valid;
  logic                    q_pop;
  kind_t                   q_kind;
  logic [IDX_W-1:0]        q_row;
  logic [IDX_W-1:0]        q_col;
  logic [ELEMENT_BITS-1:0] q_value;
  logic [OP_W-1:0]         q_op;
  cfg_wr_t                 cfg_wr;
  logic                    cfg_write;
  logic [DIM_W-1:0]        row_count_r;
  logic [DIM_W-1:0]        col_count_r;
  logic [ELEMENT_BITS-1:0] out_value;
  logic [DIM_W-1:0]        out_rows;
  logic [DIM_W-1:0]        out_cols;

  // The register bus never waits. The register index is taken from address bit 2.
  assign cfg_pready     = 1'b1;
  assign cfg_write      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_wr.wr_rows = cfg_write && (cfg_paddr[2] == REG_ROW_COUNT);
  assign cfg_wr.wr_cols = cfg_write && (cfg_paddr[2] == REG_COL_COUNT);

  // The raw register values are kept for readback; the back end applies the
  // even-and-in-range rule to form the live dimensions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_W'(MAX_DIM);
      col_count_r <= DIM_W'(MAX_DIM);
    end else begin
      if (cfg_wr.wr_rows) begin
        row_count_r <= cfg_pwdata[DIM_W-1:0];
      end
      if (cfg_wr.wr_cols) begin
        col_count_r <= cfg_pwdata[DIM_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_COL_COUNT) ? CFG_DW'(col_count_r)
                                                      : CFG_DW'(row_count_r);

  mfre_front #(
    .ELEMENT_BITS(ELEMENT_BITS),
    .IDX_W       (IDX_W),
    .IN_TDW      (IN_TDW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_kind   (q_kind),
    .q_row    (q_row),
    .q_col    (q_col),
    .q_value  (q_value),
    .q_op     (q_op)
  );

  mfre_back #(
    .MAX_DIM     (MAX_DIM),
    .ELEMENT_BITS(ELEMENT_BITS),
    .IDX_W       (IDX_W),
    .DIM_W       (DIM_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_kind   (q_kind),
    .q_row    (q_row),
    .q_col    (q_col),
    .q_value  (q_value),
    .q_op     (q_op),
    .cfg_wr   (cfg_wr),
    .cfg_dim  (cfg_pwdata[DIM_W-1:0]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_value(out_value),
    .out_rows (out_rows),
    .out_cols (out_cols)
  );

  assign out_tdata = OUT_TDW'({out_cols, out_rows, out_value});

endmodule

>>> rtl/mfre_checker.sv
module mfre_assertions #(
  parameter int ELEMENT_BITS = 32,
  parameter int DIM_W        = 7,
  parameter int OUT_TDW      = 48
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_TDW-1:0] out_tdata,
  input logic               cfg_pready
);

  a_pready_high: assert property (@(posedge clk) cfg_pready)
    else $error("register bus stalled");

  a_no_reply_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("reply valid right after reset");

  a_reply_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled reply changed");

  a_dims_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[ELEMENT_BITS] && !out_tdata[ELEMENT_BITS + DIM_W])
    else $error("reply carries an odd dimension");

endmodule

bind matrix_flip_rotate_engine_unit mfre_assertions #(
  .ELEMENT_BITS(ELEMENT_BITS),
  .DIM_W       (DIM_W),
  .OUT_TDW     (OUT_TDW)
) u_mfre_checker (.*);
